// File: rtl/dtrl_pkg.sv
// Shared types and constants for the DNS TSIG record locator.
package dtrl_pkg;

  localparam logic [15:0] TSIG_TYPE     = 16'd250;
  localparam logic [7:0]  PTR_MASK      = 8'hC0;
  localparam logic [15:0] DEFAULT_FUDGE = 16'd300;
  localparam int          HEADER_BYTES  = 12;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BADSIG  = 2'd2,
    ST_BADTIME = 2'd3
  } status_t;

  typedef struct packed {
    logic        too_short;
    logic        found;
    logic [15:0] record_begin;
    logic [15:0] mac_offset;
    logic [15:0] mac_length;
    logic [47:0] signed_time;
    logic [15:0] fudge;
    logic [47:0] now;
  } fin_t;

endpackage

// File: rtl/dtrl_parser.sv
// Byte-wise message parser that walks the sections and captures the TSIG fields.
module dtrl_parser
  import dtrl_pkg::*;
#(
  parameter int MESSAGE_MAX_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  msg_byte,
  input  logic        last_byte,
  input  logic [47:0] now_seconds,
  output fin_t        fin
);

  localparam int POS_W = $clog2(MESSAGE_MAX_BYTES + 1);

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_NAME,
    PH_LABEL,
    PH_PTR,
    PH_FIXED,
    PH_SKIP,
    PH_ALG,
    PH_ALGLABEL,
    PH_ALGPTR,
    PH_TSIGF,
    PH_DONE
  } phase_t;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   pos, pos_next, pos_inc, hoff;
  logic [3:0][15:0]   cnt, cnt_next;
  logic [15:0]        skip, skip_next, skip_dec;
  logic [3:0]         fidx, fidx_next;
  logic [15:0]        rtype, rtype_next;
  logic [15:0]        rdlen, rdlen_next;
  logic [POS_W-1:0]   rbegin, rbegin_next;
  logic [47:0]        ctime, ctime_next;
  logic [15:0]        cfudge, cfudge_next;
  logic [15:0]        cmaclen, cmaclen_next;
  logic [POS_W-1:0]   cmacoff, cmacoff_next;
  logic               found, found_next;
  logic               en, rec_done, enter, last_fixed;
  logic [2:0]         sec, nsec;
  logic [1:0]         hk;

  function automatic logic [2:0] first_section(input logic [3:0][15:0] c);
    logic [2:0] r;
    r = 3'd4;
    if (c[3] != '0) r = 3'd3;
    if (c[2] != '0) r = 3'd2;
    if (c[1] != '0) r = 3'd1;
    if (c[0] != '0) r = 3'd0;
    return r;
  endfunction

  assign pos_inc  = pos + 1'b1;
  assign en       = pos < POS_W'(MESSAGE_MAX_BYTES);
  assign hoff     = pos - POS_W'(4);
  assign hk       = hoff[2:1];
  assign sec      = first_section(cnt);
  assign skip_dec = skip - 16'd1;

  always_comb begin
    phase_next   = phase;
    cnt_next     = cnt;
    skip_next    = skip;
    fidx_next    = fidx;
    rtype_next   = rtype;
    rdlen_next   = rdlen;
    rbegin_next  = rbegin;
    ctime_next   = ctime;
    cfudge_next  = cfudge;
    cmaclen_next = cmaclen;
    cmacoff_next = cmacoff;
    found_next   = found;
    rec_done     = 1'b0;
    enter        = 1'b0;
    last_fixed   = (sec == 3'd0) ? (fidx >= 4'd3) : (fidx >= 4'd9);
    if (en) begin
      case (phase)
        PH_HEADER: begin
          if (pos >= POS_W'(4) && pos < POS_W'(HEADER_BYTES)) begin
            cnt_next[hk] = {cnt[hk][7:0], msg_byte};
          end
          if (pos == POS_W'(HEADER_BYTES - 1)) enter = 1'b1;
        end
        PH_NAME: begin
          if (msg_byte == 8'd0) begin
            fidx_next  = '0;
            rtype_next = '0;
            rdlen_next = '0;
            phase_next = PH_FIXED;
          end else if ((msg_byte & PTR_MASK) == PTR_MASK) begin
            phase_next = PH_PTR;
          end else begin
            skip_next  = {8'd0, msg_byte};
            phase_next = PH_LABEL;
          end
        end
        PH_PTR: begin
          fidx_next  = '0;
          rtype_next = '0;
          rdlen_next = '0;
          phase_next = PH_FIXED;
        end
        PH_LABEL, PH_ALGLABEL, PH_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == 16'd0) begin
            if (phase == PH_LABEL) phase_next = PH_NAME;
            else if (phase == PH_ALGLABEL) phase_next = PH_ALG;
            else rec_done = 1'b1;
          end
        end
        PH_FIXED: begin
          if (fidx <= 4'd1) rtype_next = {rtype[7:0], msg_byte};
          else if (fidx >= 4'd8) rdlen_next = {rdlen[7:0], msg_byte};
          if (last_fixed) begin
            if (sec == 3'd0 || sec[2]) begin
              rec_done = 1'b1;
            end else if (sec == 3'd3 && rtype == TSIG_TYPE) begin
              phase_next = PH_ALG;
            end else if (rdlen_next == 16'd0) begin
              rec_done = 1'b1;
            end else begin
              skip_next  = rdlen_next;
              phase_next = PH_SKIP;
            end
          end else begin
            fidx_next = fidx + 4'd1;
          end
        end
        PH_ALG: begin
          if (msg_byte == 8'd0) begin
            fidx_next    = '0;
            ctime_next   = '0;
            cfudge_next  = '0;
            cmaclen_next = '0;
            phase_next   = PH_TSIGF;
          end else if ((msg_byte & PTR_MASK) == PTR_MASK) begin
            phase_next = PH_ALGPTR;
          end else begin
            skip_next  = {8'd0, msg_byte};
            phase_next = PH_ALGLABEL;
          end
        end
        PH_ALGPTR: begin
          fidx_next    = '0;
          ctime_next   = '0;
          cfudge_next  = '0;
          cmaclen_next = '0;
          phase_next   = PH_TSIGF;
        end
        PH_TSIGF: begin
          if (fidx < 4'd6) ctime_next = {ctime[39:0], msg_byte};
          else if (fidx < 4'd8) cfudge_next = {cfudge[7:0], msg_byte};
          else cmaclen_next = {cmaclen[7:0], msg_byte};
          if (fidx >= 4'd9) begin
            found_next   = 1'b1;
            cmacoff_next = pos_inc;
            phase_next   = PH_DONE;
          end else begin
            fidx_next = fidx + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
    if (rec_done) begin
      if (!sec[2]) cnt_next[sec[1:0]] = cnt[sec[1:0]] - 16'd1;
      enter = 1'b1;
    end
    nsec = first_section(cnt_next);
    if (enter) begin
      if (nsec[2]) begin
        phase_next = PH_DONE;
      end else begin
        phase_next  = PH_NAME;
        rbegin_next = pos_inc;
      end
    end
    pos_next = en ? pos_inc : pos;
  end

  always_comb begin
    fin.too_short    = pos_next < POS_W'(HEADER_BYTES);
    fin.found        = found_next;
    fin.record_begin = 16'(rbegin_next);
    fin.mac_offset   = 16'(cmacoff_next);
    fin.mac_length   = cmaclen_next;
    fin.signed_time  = ctime_next;
    fin.fudge        = cfudge_next;
    fin.now          = now_seconds;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase   <= PH_HEADER;
      pos     <= '0;
      cnt     <= '0;
      skip    <= '0;
      fidx    <= '0;
      rtype   <= '0;
      rdlen   <= '0;
      rbegin  <= '0;
      ctime   <= '0;
      cfudge  <= DEFAULT_FUDGE;
      cmaclen <= '0;
      cmacoff <= '0;
      found   <= 1'b0;
    end else if (accept) begin
      phase   <= phase_next;
      pos     <= pos_next;
      cnt     <= cnt_next;
      skip    <= skip_next;
      fidx    <= fidx_next;
      rtype   <= rtype_next;
      rdlen   <= rdlen_next;
      rbegin  <= rbegin_next;
      ctime   <= ctime_next;
      cfudge  <= cfudge_next;
      cmaclen <= cmaclen_next;
      cmacoff <= cmacoff_next;
      found   <= found_next;
    end
  end

endmodule

// File: rtl/dtrl_result.sv
// Finish register, time window check and output register of the locator.
module dtrl_result
  import dtrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fin_load,
  input  fin_t        fin,
  input  logic        res_stall,
  output logic        msg_stall,
  output logic        res_valid,
  output logic [1:0]  status,
  output logic [15:0] record_offset,
  output logic [15:0] mac_offset,
  output logic [15:0] mac_length,
  output logic [47:0] signed_time,
  output logic [15:0] time_fudge
);

  fin_t        fin_q;
  logic        fin_valid;
  logic        out_free, fin_take;
  logic [47:0] diff;
  status_t     status_next;

  assign out_free  = !res_valid || !res_stall;
  assign fin_take  = fin_valid && out_free;
  assign msg_stall = fin_valid && !out_free;

  assign diff = (fin_q.now >= fin_q.signed_time) ? fin_q.now - fin_q.signed_time
                                                  : fin_q.signed_time - fin_q.now;

  always_comb begin
    if (fin_q.too_short) status_next = ST_SHORT;
    else if (!fin_q.found) status_next = ST_BADSIG;
    else if (diff > {32'd0, fin_q.fudge}) status_next = ST_BADTIME;
    else status_next = ST_FOUND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_load) begin
      fin_valid <= 1'b1;
    end else if (fin_take) begin
      fin_valid <= 1'b0;
    end
    if (fin_load) begin
      fin_q <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (fin_take) begin
      status <= status_next;
      if (status_next == ST_SHORT || status_next == ST_BADSIG) begin
        record_offset <= '0;
        mac_offset    <= '0;
        mac_length    <= '0;
        signed_time   <= '0;
        time_fudge    <= '0;
      end else begin
        record_offset <= fin_q.record_begin;
        mac_offset    <= fin_q.mac_offset;
        mac_length    <= fin_q.mac_length;
        signed_time   <= fin_q.signed_time;
        time_fudge    <= fin_q.fudge;
      end
    end
  end

endmodule

// File: rtl/dns_tsig_record_locator.sv
// The result goes through the finish register, then the output register, to res_valid.
// Throughput: one message byte per cycle while msg_stall is low; one result per message.
// Input stalls only while one result waits in the output register and one more waits behind it.
// Reset (rst, synchronous) returns the parser to the header phase and empties both registers.
// The parser also returns to its reset state after every last byte.
module dns_tsig_record_locator
  import dtrl_pkg::*;
#(
  parameter int MESSAGE_MAX_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  msg_byte,
  input  logic        last_byte,
  input  logic [47:0] now_seconds,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [15:0] record_offset,
  output logic [15:0] mac_offset,
  output logic [15:0] mac_length,
  output logic [47:0] signed_time,
  output logic [15:0] time_fudge
);

  logic accept;
  fin_t fin;

  assign accept = msg_valid && !msg_stall;

  dtrl_parser #(
    .MESSAGE_MAX_BYTES(MESSAGE_MAX_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .msg_byte   (msg_byte),
    .last_byte  (last_byte),
    .now_seconds(now_seconds),
    .fin        (fin)
  );

  dtrl_result u_result (
    .clk          (clk),
    .rst          (rst),
    .fin_load     (accept && last_byte),
    .fin          (fin),
    .res_stall    (res_stall),
    .msg_stall    (msg_stall),
    .res_valid    (res_valid),
    .status       (status),
    .record_offset(record_offset),
    .mac_offset   (mac_offset),
    .mac_length   (mac_length),
    .signed_time  (signed_time),
    .time_fudge   (time_fudge)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    msg_stall |-> (res_valid && res_stall))
    else $error("input stalled while output register could drain");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status == ST_SHORT || status == ST_BADSIG)) |->
      (record_offset == 16'd0 && mac_offset == 16'd0 && mac_length == 16'd0 &&
       signed_time == 48'd0 && time_fudge == 16'd0))
    else $error("failed result carries nonzero fields");

  a_mac_after_record: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status == ST_FOUND || status == ST_BADTIME)) |->
      (mac_offset > record_offset))
    else $error("MAC offset not beyond record start");
`endif

endmodule

// File: test/dtrl_checker.sv
// Checker for the DNS TSIG record locator: predicts each result from the byte stream and compares.
module dtrl_checker
  import dtrl_pkg::*;
#(
  parameter int MAX_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  input  logic        msg_stall,
  input  logic [7:0]  msg_byte,
  input  logic        last_byte,
  input  logic [47:0] now_seconds,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [1:0]  status,
  input  logic [15:0] record_offset,
  input  logic [15:0] mac_offset,
  input  logic [15:0] mac_length,
  input  logic [47:0] signed_time,
  input  logic [15:0] time_fudge,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    SCAN_HEADER,
    SCAN_NAME,
    SCAN_LABEL,
    SCAN_PTR,
    SCAN_FIXED,
    SCAN_RDATA,
    SCAN_ALG,
    SCAN_ALG_LABEL,
    SCAN_ALG_PTR,
    SCAN_TSIG,
    SCAN_DONE
  } scan_t;

  typedef struct packed {
    status_t     st;
    logic [15:0] rec_off;
    logic [15:0] mac_off;
    logic [15:0] mac_len;
    logic [47:0] tsig_time;
    logic [15:0] fudge;
  } locate_t;

  scan_t       phase;
  logic [16:0] pos;
  logic [15:0] cnt [4];
  logic [16:0] skip_left;
  logic [3:0]  fidx;
  logic [15:0] rtype;
  logic [15:0] rdlen;
  logic [16:0] rbegin;
  logic [47:0] tsig_time;
  logic [15:0] tsig_fudge;
  logic [15:0] tsig_maclen;
  logic [16:0] tsig_macoff;
  logic        tsig_seen;

  locate_t expected_q[$];
  locate_t want;

  task automatic clear_scan();
    phase       = SCAN_HEADER;
    pos         = '0;
    for (int k = 0; k < 4; k++) cnt[k] = '0;
    skip_left   = '0;
    fidx        = '0;
    rtype       = '0;
    rdlen       = '0;
    rbegin      = '0;
    tsig_time   = '0;
    tsig_fudge  = DEFAULT_FUDGE;
    tsig_maclen = '0;
    tsig_macoff = '0;
    tsig_seen   = 1'b0;
  endtask

  function automatic int live_section();
    for (int k = 0; k < 4; k++) begin
      if (cnt[k] != 16'd0) return k;
    end
    return 4;
  endfunction

  task automatic open_record();
    if (live_section() >= 4) begin
      phase = SCAN_DONE;
    end else begin
      phase  = SCAN_NAME;
      rbegin = pos + 17'd1;
    end
  endtask

  task automatic close_record();
    int k;
    k = live_section();
    if (k < 4) cnt[k] = cnt[k] - 16'd1;
    open_record();
  endtask

  task automatic name_end();
    fidx  = '0;
    rtype = '0;
    rdlen = '0;
    phase = SCAN_FIXED;
  endtask

  task automatic tsig_begin();
    fidx        = '0;
    tsig_time   = '0;
    tsig_fudge  = '0;
    tsig_maclen = '0;
    phase       = SCAN_TSIG;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    int k;
    int need;
    case (phase)
      SCAN_HEADER: begin
        if (pos >= 17'd4 && pos < HEADER_BYTES) begin
          k = (int'(pos - 17'd4) >> 1) & 3;
          cnt[k] = {cnt[k][7:0], b};
        end
        if (pos == HEADER_BYTES - 1) open_record();
      end
      SCAN_NAME: begin
        if (b == 8'd0) begin
          name_end();
        end else if ((b & PTR_MASK) == PTR_MASK) begin
          phase = SCAN_PTR;
        end else begin
          skip_left = {9'd0, b};
          phase     = SCAN_LABEL;
        end
      end
      SCAN_PTR: name_end();
      SCAN_LABEL, SCAN_ALG_LABEL, SCAN_RDATA: begin
        skip_left = skip_left - 17'd1;
        if (skip_left == 17'd0) begin
          if (phase == SCAN_LABEL) phase = SCAN_NAME;
          else if (phase == SCAN_ALG_LABEL) phase = SCAN_ALG;
          else close_record();
        end
      end
      SCAN_FIXED: begin
        k    = live_section();
        need = (k == 0) ? 4 : 10;
        if (fidx <= 4'd1) rtype = {rtype[7:0], b};
        else if (fidx >= 4'd8) rdlen = {rdlen[7:0], b};
        if (int'(fidx) + 1 >= need) begin
          if (k == 0 || k >= 4) begin
            close_record();
          end else if (k == 3 && rtype == TSIG_TYPE) begin
            phase = SCAN_ALG;
          end else if (rdlen == 16'd0) begin
            close_record();
          end else begin
            skip_left = {1'b0, rdlen};
            phase     = SCAN_RDATA;
          end
        end else begin
          fidx = fidx + 4'd1;
        end
      end
      SCAN_ALG: begin
        if (b == 8'd0) begin
          tsig_begin();
        end else if ((b & PTR_MASK) == PTR_MASK) begin
          phase = SCAN_ALG_PTR;
        end else begin
          skip_left = {9'd0, b};
          phase     = SCAN_ALG_LABEL;
        end
      end
      SCAN_ALG_PTR: tsig_begin();
      SCAN_TSIG: begin
        if (fidx < 4'd6) tsig_time = {tsig_time[39:0], b};
        else if (fidx < 4'd8) tsig_fudge = {tsig_fudge[7:0], b};
        else tsig_maclen = {tsig_maclen[7:0], b};
        if (fidx >= 4'd9) begin
          tsig_seen   = 1'b1;
          tsig_macoff = pos + 17'd1;
          phase       = SCAN_DONE;
        end else begin
          fidx = fidx + 4'd1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic locate_byte(input logic [7:0] b, input logic lst, input logic [47:0] nw);
    locate_t     r;
    logic [47:0] diff;
    if (pos < MAX_BYTES) begin
      scan_byte(b);
      pos = pos + 17'd1;
    end
    if (lst) begin
      r = '0;
      if (pos < HEADER_BYTES) begin
        r.st = ST_SHORT;
      end else if (!tsig_seen) begin
        r.st = ST_BADSIG;
      end else begin
        diff        = (nw >= tsig_time) ? nw - tsig_time : tsig_time - nw;
        r.st        = (diff > 48'(tsig_fudge)) ? ST_BADTIME : ST_FOUND;
        r.rec_off   = rbegin[15:0];
        r.mac_off   = tsig_macoff[15:0];
        r.mac_len   = tsig_maclen;
        r.tsig_time = tsig_time;
        r.fudge     = tsig_fudge;
      end
      expected_q.push_back(r);
      clear_scan();
    end
  endtask

  function automatic void check_field(string fname, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d", $time, status);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 48'(want.st), 48'(status));
          check_field("record_offset", 48'(want.rec_off), 48'(record_offset));
          check_field("mac_offset", 48'(want.mac_off), 48'(mac_offset));
          check_field("mac_length", 48'(want.mac_len), 48'(mac_length));
          check_field("signed_time", want.tsig_time, signed_time);
          check_field("time_fudge", 48'(want.fudge), 48'(time_fudge));
        end
      end
      if (msg_valid && !msg_stall) locate_byte(msg_byte, last_byte, now_seconds);
    end
    pending = expected_q.size();
  end

endmodule

// File: test/dns_tsig_record_locator_tb.sv
// Testbench top for the DNS TSIG record locator: message stimulus, flow control and verdict.
module dns_tsig_record_locator_tb;
  import dtrl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MSG_MAX     = 65535;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 400;

  localparam int NAME_ANY    = -1;
  localparam int NAME_LABELS = 0;
  localparam int NAME_ROOT   = 1;
  localparam int NAME_PTR    = 2;
  localparam int NAME_WIDE   = 3;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        msg_valid   = 1'b0;
  logic        msg_stall;
  logic [7:0]  msg_byte    = 8'd0;
  logic        last_byte   = 1'b0;
  logic [47:0] now_seconds = 48'd0;
  logic        res_valid;
  logic        res_stall   = 1'b0;
  logic [1:0]  status;
  logic [15:0] record_offset;
  logic [15:0] mac_offset;
  logic [15:0] mac_length;
  logic [47:0] signed_time;
  logic [15:0] time_fudge;
  int          fail_count;
  int          pending;

  logic [7:0]  msg_buf[$];
  bit          quiet = 1'b0;
  bit          press_req = 1'b0;
  bit          tsig_in_answer = 1'b0;
  int          sent_bytes = 0;
  int          cycles = 0;

  dns_tsig_record_locator #(.MESSAGE_MAX_BYTES(MSG_MAX)) dut (.*);

  dtrl_checker #(.MAX_BYTES(MSG_MAX)) u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] near_time(logic [47:0] stamp, logic [15:0] fz, bit in_win);
    logic [47:0] delta;
    delta = in_win ? 48'($urandom_range(0, fz)) : 48'(fz) + 48'd1 + 48'($urandom_range(0, 5000));
    return $urandom_range(0, 1) ? stamp + delta : stamp - delta;
  endfunction

  task automatic put8(input logic [7:0] b);
    msg_buf.push_back(b);
  endtask

  task automatic put16(input logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endtask

  task automatic put_rand(input int n);
    repeat (n) put8(8'($urandom));
  endtask

  task automatic cut_to(input int len);
    while (msg_buf.size() > len) void'(msg_buf.pop_back());
  endtask

  task automatic push_name(input int style);
    int s;
    int len;
    s = style;
    if (s == NAME_ANY) begin
      case ($urandom_range(0, 9))
        7:       s = NAME_ROOT;
        8:       s = NAME_PTR;
        9:       s = NAME_WIDE;
        default: s = NAME_LABELS;
      endcase
    end
    if (s == NAME_LABELS) begin
      repeat ($urandom_range(0, 3)) begin
        len = ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 12);
        put8(8'(len));
        put_rand(len);
      end
    end else if (s == NAME_WIDE) begin
      repeat ($urandom_range(1, 2)) begin
        len = $urandom_range(64, 191);
        put8(8'(len));
        put_rand(len);
      end
    end
    if (s == NAME_PTR || (s == NAME_LABELS && $urandom_range(0, 2) == 0)) begin
      put8(PTR_MASK | 8'($urandom_range(0, 63)));
      put8(8'($urandom));
    end else begin
      put8(8'd0);
    end
  endtask

  task automatic push_record(input int section, input int style);
    logic [15:0] rtype;
    int          rdlen;
    push_name(style);
    if (section == 0) begin
      put_rand(4);
    end else begin
      rtype = 16'($urandom);
      if (section == 3 && rtype == TSIG_TYPE) rtype = TSIG_TYPE + 16'd1;
      if (section != 3 && (tsig_in_answer || $urandom_range(0, 9) == 0)) rtype = TSIG_TYPE;
      rdlen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16);
      put16(rtype);
      put_rand(6);
      put16(16'(rdlen));
      put_rand(rdlen);
    end
  endtask

  task automatic build_dns(input int qd, input int an, input int ns, input int arx,
                           input bit with_tsig, input int style, input logic [15:0] fz,
                           input logic [47:0] stamp, input logic [15:0] maclen,
                           input int tail);
    msg_buf.delete();
    put_rand(4);
    put16(16'(qd));
    put16(16'(an));
    put16(16'(ns));
    put16(16'(arx + int'(with_tsig)));
    repeat (qd) push_record(0, style);
    repeat (an) push_record(1, style);
    repeat (ns) push_record(2, style);
    repeat (arx) push_record(3, style);
    if (with_tsig) begin
      push_name(style);
      put16(TSIG_TYPE);
      put_rand(8);
      push_name(style);
      put16(stamp[47:32]);
      put16(stamp[31:16]);
      put16(stamp[15:0]);
      put16(fz);
      put16(maclen);
      put_rand(tail);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic [47:0] nw);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 12);
      msg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_valid   <= 1'b1;
    msg_byte    <= b;
    last_byte   <= lst;
    now_seconds <= nw;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
  endtask

  task automatic send_message(input logic [47:0] nw);
    int n;
    n = msg_buf.size();
    for (int i = 0; i < n; i++) begin
      send_byte(msg_buf[i], i == n - 1, (i == n - 1) ? nw : rand48());
    end
    sent_bytes += n;
  endtask

  task automatic random_message();
    int          pick;
    logic [15:0] fz;
    logic [47:0] stamp;
    logic [47:0] nw;
    pick  = $urandom_range(0, 99);
    stamp = rand48();
    case ($urandom_range(0, 7))
      0:       fz = 16'd0;
      1:       fz = 16'hFFFF;
      2:       fz = 16'($urandom);
      default: fz = 16'($urandom_range(0, 600));
    endcase
    nw = rand48();
    if (pick < 70) begin
      build_dns($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 1),
                $urandom_range(0, 1), 1'b1, NAME_ANY, fz, stamp,
                ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32)),
                $urandom_range(0, 20));
      nw = near_time(stamp, fz, $urandom_range(0, 3) != 0);
      if (pick >= 60) cut_to($urandom_range(1, msg_buf.size()));
    end else if (pick < 78) begin
      build_dns($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 1),
                $urandom_range(0, 2), 1'b0, NAME_ANY, fz, stamp, 16'd0, 0);
    end else if (pick < 86) begin
      msg_buf.delete();
      put_rand($urandom_range(1, 11));
    end else begin
      msg_buf.delete();
      put_rand($urandom_range(1, 60));
      if (msg_buf.size() >= 12 && $urandom_range(0, 1)) begin
        for (int k = 4; k < 12; k += 2) begin
          msg_buf[k]     = 8'd0;
          msg_buf[k + 1] = 8'($urandom_range(0, 2));
        end
      end
    end
    send_message(nw);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (press_req) begin
        press_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        res_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [47:0] stamp;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    msg_buf.delete();
    put8(8'h00);
    send_message(rand48());
    msg_buf.delete();
    repeat (11) put8(8'hFF);
    send_message(48'hFFFF_FFFF_FFFF);
    msg_buf.delete();
    repeat (12) put8(8'h00);
    send_message(48'd0);
    build_dns(0, 0, 0, 0, 1'b1, NAME_ANY, DEFAULT_FUDGE, rand48(), 16'd4, 4);
    cut_to(HEADER_BYTES);
    send_message(rand48());

    stamp = rand48();
    build_dns(1, 0, 0, 0, 1'b1, NAME_ANY, DEFAULT_FUDGE, stamp, 16'd16, 16);
    send_message(near_time(stamp, DEFAULT_FUDGE, 1'b1));
    build_dns(1, 1, 1, 0, 1'b1, NAME_ROOT, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 16'd0, 0);
    send_message(48'd0);
    build_dns(0, 0, 0, 0, 1'b1, NAME_ROOT, 16'hFFFF, 48'd0, 16'hFFFF, 4);
    send_message(48'd65535);
    stamp = rand48();
    build_dns(0, 1, 0, 0, 1'b1, NAME_LABELS, 16'd0, stamp, 16'd32, 0);
    send_message(stamp);
    send_message(stamp + 48'd1);

    build_dns(2, 2, 2, 1, 1'b1, NAME_PTR, DEFAULT_FUDGE, stamp, 16'd8, 8);
    send_message(near_time(stamp, DEFAULT_FUDGE, 1'b1));
    build_dns(1, 1, 1, 1, 1'b1, NAME_ROOT, DEFAULT_FUDGE, stamp, 16'd8, 8);
    send_message(near_time(stamp, DEFAULT_FUDGE, 1'b0));
    build_dns(0, 0, 0, 0, 1'b1, NAME_WIDE, DEFAULT_FUDGE, stamp, 16'd8, 2);
    send_message(stamp);

    tsig_in_answer = 1'b1;
    build_dns(0, 2, 1, 1, 1'b0, NAME_ANY, DEFAULT_FUDGE, stamp, 16'd0, 0);
    send_message(stamp);
    build_dns(0, 1, 0, 0, 1'b1, NAME_ANY, DEFAULT_FUDGE, stamp, 16'd0, 0);
    send_message(stamp);
    tsig_in_answer = 1'b0;

    build_dns(0, 0, 0, 2, 1'b1, NAME_ROOT, DEFAULT_FUDGE, stamp, 16'd12, 12);
    send_message(stamp);
    build_dns(1, 1, 1, 0, 1'b0, NAME_ROOT, DEFAULT_FUDGE, stamp, 16'd0, 0);
    send_message(stamp);
    build_dns(1, 0, 0, 0, 1'b1, NAME_ROOT, DEFAULT_FUDGE, stamp, 16'd8, 0);
    cut_to(msg_buf.size() - 1);
    send_message(stamp);
    build_dns(1, 0, 0, 0, 1'b1, NAME_ROOT, DEFAULT_FUDGE, stamp, 16'd8, 0);
    cut_to(msg_buf.size() - 7);
    send_message(stamp);
    msg_buf.delete();
    repeat (20) put8(8'hFF);
    send_message(rand48());

    quiet     = 1'b1;
    press_req = 1'b1;
    repeat (10) begin
      msg_buf.delete();
      put_rand($urandom_range(1, 11));
      send_message(rand48());
    end
    quiet = 1'b0;

    while (sent_bytes < 1700) random_message();
    quiet = 1'b1;
    repeat (2) random_message();

    @(negedge clk);
    msg_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dtrl_pkg.sv
rtl/dtrl_parser.sv
rtl/dtrl_result.sv
rtl/dns_tsig_record_locator.sv
test/dtrl_checker.sv
test/dns_tsig_record_locator_tb.sv
